>>> rtl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types, constants and helper functions for the combining-tree barrier.
// ----------------------------------------------------------------------------
package ctb_pkg;

	// Tree size and field widths.
	localparam int MaxParticipants = 64;
	localparam int NodeW           = 7;
	localparam int IdxW            = 6;
	localparam int CountW          = 2;
	localparam int DoneW           = 3;
	localparam int CfgAddrW        = 3;
	localparam int CfgDataW        = 32;

	// Register map.
	localparam logic [CfgAddrW-1:0] RegThreadCount      = 3'd0;
	localparam logic [NodeW-1:0]    ThreadCountResetVal = 7'd4;

	// Saturation limit of the completed-node counter.
	localparam logic [DoneW-1:0] DoneMax = 3'd7;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} ctb_state_t;

	// Request from the sequencer to the count store.
	typedef struct packed {
		logic              rd_en;
		logic [IdxW-1:0]   rd_idx;
		logic              wr_en;
		logic [IdxW-1:0]   wr_idx;
		logic [CountW-1:0] wr_data;
		logic              clr_one;
		logic              clr_all;
	} ctb_store_req_t;

	// Clamp the programmed thread count to 1..MaxParticipants.
	function automatic logic [NodeW-1:0] effective_count(input logic [NodeW-1:0] tc);
		logic [NodeW-1:0] n;
		n = tc;
		if (n == '0) begin
			n = NodeW'(1);
		end else if (n > NodeW'(MaxParticipants)) begin
			n = NodeW'(MaxParticipants);
		end
		return n;
	endfunction

	// Arrivals a node expects: one for itself plus one per existing child.
	function automatic logic [CountW-1:0] expected_arrivals(input logic [NodeW-1:0] node,
			input logic [NodeW-1:0] n);
		logic [NodeW:0]    left;
		logic [NodeW:0]    right;
		logic [CountW-1:0] k;
		left  = {node, 1'b0};
		right = {node, 1'b1};
		k     = CountW'(1);
		if (left <= {1'b0, n}) begin
			k = k + CountW'(1);
		end
		if (right <= {1'b0, n}) begin
			k = k + CountW'(1);
		end
		return k;
	endfunction

	// Storage index to node number: index zero holds node 64.
	function automatic logic [NodeW-1:0] idx_to_node(input logic [IdxW-1:0] idx);
		return {(idx == '0), idx};
	endfunction

endpackage

>>> rtl/ctb_count_store.sv
// ----------------------------------------------------------------------------
// ctb_count_store
// Per-node remaining counts, kept in a memory with one valid bit per entry.
// ----------------------------------------------------------------------------
module ctb_count_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctb_pkg::ctb_store_req_t       req,
	input  logic [ctb_pkg::NodeW-1:0]     n_eff,
	output logic [ctb_pkg::CountW-1:0]    rem
);

	logic [ctb_pkg::CountW-1:0]  mem [ctb_pkg::MaxParticipants];
	logic [ctb_pkg::MaxParticipants-1:0] valid_q;
	logic [ctb_pkg::CountW-1:0]  rd_data_q;
	logic                        rd_valid_q;
	logic [ctb_pkg::IdxW-1:0]    rd_idx_q;

	// Memory write port and registered read port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_idx];
			rd_idx_q  <= req.rd_idx;
		end
	end

	// Valid bits: a cleared entry reads as its expected arrival count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_idx];
			end
			if (req.clr_all) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_idx] <= 1'b1;
			end else if (req.clr_one) begin
				valid_q[req.wr_idx] <= 1'b0;
			end
		end
	end

	// Count of the node read in the previous cycle.
	assign rem = rd_valid_q ? rd_data_q
		: ctb_pkg::expected_arrivals(ctb_pkg::idx_to_node(rd_idx_q), n_eff);

endmodule

>>> rtl/combining_tree_barrier.sv
// An arrival that visits k tree nodes (1 to 7) holds the block from its accept
// through one evaluate step per node, paced by the single count-store read port.
// An out-of-range thread id gives its result in the cycle after it is accepted.
// The next item is taken once the block is idle and its result slot is free.
// Reset is asynchronous: counts read as expected values through per-node valid bits,
// so no clearing pass is needed. Thread count resets to 4 and the phase to zero.
// ----------------------------------------------------------------------------
// combining_tree_barrier
// Heap-ordered combining-tree barrier with a climb-one-node-per-cycle sequencer.
// ----------------------------------------------------------------------------
module combining_tree_barrier (
	input  logic                             clk,
	input  logic                             arst_n,
	// Arrival stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [6:0] thread_id, [7] zero
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // [0] released, [1] phase,
	                                                    // [4:2] nodes_completed, [7:5] zero
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ctb_pkg::CfgAddrW-1:0]     paddr,
	input  logic [ctb_pkg::CfgDataW-1:0]     pwdata,
	output logic [ctb_pkg::CfgDataW-1:0]     prdata,
	output logic                             pready
);

	ctb_pkg::ctb_state_t              state_q, state_d;
	ctb_pkg::ctb_store_req_t          req;
	logic [ctb_pkg::NodeW-1:0]        thread_count_q;
	logic [ctb_pkg::NodeW-1:0]        n_eff;
	logic [ctb_pkg::NodeW-1:0]        node_q, node_d;
	logic [ctb_pkg::DoneW-1:0]        done_q, done_d;
	logic                             phase_q, phase_d;
	logic [ctb_pkg::CountW-1:0]       rem;
	logic                             out_valid_q;
	logic                             out_load;
	logic                             out_released_q, out_released_d;
	logic [ctb_pkg::DoneW-1:0]        out_done_q, out_done_d;
	logic                             cfg_write;
	logic                             in_accept;
	logic [ctb_pkg::NodeW-1:0]        thread_id;
	logic                             id_ok;
	logic [ctb_pkg::NodeW-1:0]        parent;

	// Configuration register access.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr == ctb_pkg::RegThreadCount);
	assign prdata    = (paddr == ctb_pkg::RegThreadCount)
		? {{(ctb_pkg::CfgDataW-ctb_pkg::NodeW){1'b0}}, thread_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thread_count_q <= ctb_pkg::ThreadCountResetVal;
		end else if (cfg_write) begin
			thread_count_q <= pwdata[ctb_pkg::NodeW-1:0];
		end
	end

	assign n_eff = ctb_pkg::effective_count(thread_count_q);

	// Input handshake and range check.
	assign s_tready  = (state_q == ctb_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign in_accept = s_tvalid && s_tready;
	assign thread_id = s_tdata[ctb_pkg::NodeW-1:0];
	assign id_ok     = (thread_id != '0) && (thread_id <= n_eff);
	assign parent    = node_q >> 1;

	// Count store.
	ctb_count_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.n_eff  (n_eff),
		.rem    (rem)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctb_pkg::ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// Climb registers.
	always_ff @(posedge clk) begin
		node_q <= node_d;
		done_q <= done_d;
	end

	// Next state, store requests and result loading.
	always_comb begin
		state_d        = state_q;
		phase_d        = phase_q;
		node_d         = node_q;
		done_d         = done_q;
		out_load       = 1'b0;
		out_released_d = 1'b0;
		out_done_d     = '0;
		req            = '0;
		req.clr_all    = cfg_write;
		req.wr_idx     = node_q[ctb_pkg::IdxW-1:0];
		case (state_q)
			ctb_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (id_ok) begin
						req.rd_en  = 1'b1;
						req.rd_idx = thread_id[ctb_pkg::IdxW-1:0];
						node_d     = thread_id;
						done_d     = '0;
						state_d    = ctb_pkg::ST_EVAL;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			ctb_pkg::ST_EVAL: begin
				if (rem > ctb_pkg::CountW'(1)) begin
					// Node still waits for more arrivals.
					req.wr_en      = 1'b1;
					req.wr_data    = rem - ctb_pkg::CountW'(1);
					out_load       = 1'b1;
					out_done_d     = done_q;
					state_d        = ctb_pkg::ST_IDLE;
				end else begin
					// Node completes: reload it and move on.
					req.clr_one = 1'b1;
					done_d      = (done_q == ctb_pkg::DoneMax) ? done_q
						: done_q + ctb_pkg::DoneW'(1);
					if (node_q == ctb_pkg::NodeW'(1)) begin
						phase_d        = ~phase_q;
						out_load       = 1'b1;
						out_released_d = 1'b1;
						out_done_d     = done_d;
						state_d        = ctb_pkg::ST_IDLE;
					end else begin
						req.rd_en  = 1'b1;
						req.rd_idx = parent[ctb_pkg::IdxW-1:0];
						node_d     = parent;
					end
				end
			end
			default: begin
				state_d = ctb_pkg::ST_IDLE;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_released_q <= out_released_d;
			out_done_q     <= out_done_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_done_q, phase_q, out_released_q};

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the combining-tree barrier. Thread arrivals are
// streamed in from a queue, and a local model of the tree counts predicts
// every result item. Results are compared field by field as they leave the
// block. The thread count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
	import ctb_pkg::*;

	localparam logic [CfgAddrW-1:0] AddrUnmapped  = 3'd4;
	localparam int                  WatchdogLimit = 2000;
	localparam int                  HoldCycles    = 300;
	localparam int                  DrainCycles   = 10;

	typedef struct packed {
		logic             released;
		logic             phase;
		logic [DoneW-1:0] nodes_done;
	} barrier_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;   // [6:0] thread_id, [7] zero
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;         // [0] released, [1] phase, [4:2] nodes_completed
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [CfgAddrW-1:0] paddr    = '0;
	logic [CfgDataW-1:0] pwdata   = '0;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	// Model of the tree: pending arrivals per node, phase and thread count.
	logic [CountW-1:0] node_left [1:MaxParticipants];
	logic              model_phase;
	logic [NodeW-1:0]  model_threads;

	logic [NodeW-1:0] arrivals_pending [$];
	barrier_result_t  expected_results [$];

	int send_idle_pct = 32;
	int recv_idle_pct = 82;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int idle_run      = 0;
	int err_count     = 0;
	int stim_count    = 0;

	combining_tree_barrier DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Thread count after clamping to the legal range.
	function automatic int tree_size();
		int n;
		n = model_threads;
		if (n < 1) n = 1;
		if (n > MaxParticipants) n = MaxParticipants;
		return n;
	endfunction

	// A node waits for itself and for each of its children that exists.
	function automatic int node_quota(int node, int n);
		return 1 + int'(2 * node <= n) + int'(2 * node + 1 <= n);
	endfunction

	function automatic void reload_tree();
		int n;
		n = tree_size();
		for (int j = 1; j <= MaxParticipants; j++) begin
			node_left[j] = (j <= n) ? CountW'(node_quota(j, n)) : '0;
		end
	endfunction

	// One arrival: count down the leaf and climb while nodes complete.
	function automatic barrier_result_t climb_tree(logic [NodeW-1:0] thread_id);
		barrier_result_t r;
		int              n;
		int              node;
		bit              stop;
		r    = '0;
		n    = tree_size();
		node = thread_id;
		stop = 1'b0;
		if (node >= 1 && node <= n) begin
			while (!stop) begin
				if (node_left[node] > 1) begin
					node_left[node] = node_left[node] - 1'b1;
					stop = 1'b1;
				end else begin
					// A zero count also lands here and completes the node.
					node_left[node] = CountW'(node_quota(node, n));
					if (r.nodes_done != DoneMax) r.nodes_done = r.nodes_done + 1'b1;
					if (node == 1) begin
						r.released  = 1'b1;
						model_phase = ~model_phase;
						stop        = 1'b1;
					end else begin
						node = node / 2;
					end
				end
			end
		end
		r.phase = model_phase;
		return r;
	endfunction

	// Arrival driver: holds an item until it is taken, then offers the next one.
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (arrivals_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {1'b0, arrivals_pending.pop_front()};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (hold_reqs != hold_seen) begin
				hold_seen <= hold_reqs;
				hold_left <= HoldCycles;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Monitor: predict on each accepted arrival, check each accepted result.
	always @(posedge clk) begin : monitor
		barrier_result_t want;
		bit              moved;
		moved = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(climb_tree(s_tdata[6:0]));
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (expected_results.size() == 0) begin
					$error("result item with no arrival waiting: %h", m_tdata);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[0] !== want.released) begin
						$error("released: expected %0d, actual %0d", want.released, m_tdata[0]);
						err_count++;
					end
					if (m_tdata[1] !== want.phase) begin
						$error("phase: expected %0d, actual %0d", want.phase, m_tdata[1]);
						err_count++;
					end
					if (m_tdata[4:2] !== want.nodes_done) begin
						$error("nodes_completed: expected %0d, actual %0d",
							want.nodes_done, m_tdata[4:2]);
						err_count++;
					end
				end
			end
			// Watchdog on cycles in which no item moves.
			if (moved) begin
				idle_run <= 0;
			end else if (idle_run >= WatchdogLimit) begin
				$display("tb: done, errors");
				$finish;
			end else begin
				idle_run <= idle_run + 1;
			end
		end
	end

	// Wait until every queued arrival has been answered, then let the block settle.
	task automatic settle();
		@(negedge clk);
		while (arrivals_pending.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == RegThreadCount) begin
			model_threads = data[NodeW-1:0];
			reload_tree();
		end
	endtask

	task automatic push_arrival(input int id);
		arrivals_pending.push_back(NodeW'(id));
		stim_count++;
	endtask

	// One barrier episode: every thread at most once, shuffled unless in order;
	// shuffled ones also mix in stray ids, and now and then a thread never shows up.
	task automatic queue_episode(input int n, input bit in_order);
		int ids [$];
		int k;
		int tmp;
		for (int j = 1; j <= n; j++) ids.push_back(j);
		if (!in_order) begin
			for (int j = n - 1; j > 0; j--) begin
				k       = $urandom_range(j);
				tmp     = ids[j];
				ids[j]  = ids[k];
				ids[k]  = tmp;
			end
		end
		foreach (ids[j]) begin
			if (!in_order && $urandom_range(99) < 8) push_arrival($urandom_range(127));
			if (in_order || $urandom_range(99) >= 4) push_arrival(ids[j]);
		end
	endtask

	initial begin : stimulus
		int directed_ids [] = '{0, 5, 127, 64, 1, 2, 3, 4, 2, 2, 4, 3, 1, 8, 16, 32};
		int phase_counts [] = '{2, 3, 37, 64, 1, 17, 6};
		int n;
		int phase_start;
		model_threads = ThreadCountResetVal;
		model_phase   = 1'b0;
		reload_tree();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset thread count of four.
		foreach (directed_ids[j]) push_arrival(directed_ids[j]);

		// A write to an unmapped address leaves the thread count alone.
		cfg_write(AddrUnmapped, 32'h0000_0007);
		push_arrival(4);
		push_arrival(1);
		push_arrival(5);

		// Thread count zero behaves as a single thread.
		cfg_write(RegThreadCount, 32'h0000_0000);
		push_arrival(1);
		push_arrival(1);
		push_arrival(2);

		// All ones saturates to the full tree; an ordered episode climbs all seven levels.
		cfg_write(RegThreadCount, 32'hFFFF_FFFF);
		queue_episode(MaxParticipants, 1'b1);
		hold_reqs++;
		queue_episode(MaxParticipants, 1'b0);

		// Random phases over several thread counts; idling patterns change as they go.
		foreach (phase_counts[p]) begin
			if (p == 2) begin
				send_idle_pct = 82;
				recv_idle_pct = 32;
			end else if (p == 5) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			cfg_write(RegThreadCount, {$urandom} & 32'hFFFF_FF80 | phase_counts[p]);
			n           = tree_size();
			phase_start = stim_count;
			while (stim_count - phase_start < 45) begin
				queue_episode(n, 1'b0);
				if (p == 3 && stim_count - phase_start < 45) settle();
			end
		end

		settle();
		if (err_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/ctb_pkg.sv
rtl/ctb_count_store.sv
rtl/combining_tree_barrier.sv
tb/tb.sv
